// ===== hdl/avccr_pkg.sv =====
package avccr_pkg;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TRUNC    = 2'd1;
	localparam logic [1:0] ERR_VERSION  = 2'd2;
	localparam logic [1:0] ERR_RESERVED = 2'd3;

	localparam logic [2:0] MIN_RECORD_BYTES = 3'd7;
	localparam logic [7:0] VERSION_ONE      = 8'd1;
	localparam logic [5:0] RES6_ALL_ONES    = 6'h3F;
	localparam logic [2:0] RES3_ALL_ONES    = 3'd7;

	typedef struct packed {
		logic       record_ok;
		logic [1:0] error_code;
		logic [7:0] profile;
		logic [7:0] compatibility;
		logic [7:0] level;
		logic [1:0] length_size_minus_one;
		logic [4:0] sps_count;
		logic [7:0] pps_count;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] record_byte;
		logic       end_of_record;
	} byte_item_t;

endpackage

// ===== hdl/avccr_in_stage.sv =====
module avccr_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            record_byte,
	input  logic                  end_of_record,
	input  logic                  advance,
	output avccr_pkg::byte_item_t item_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       accept;

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= record_byte;
			last_s1 <= end_of_record;
		end
	end

	assign item_s1 = '{valid: valid_s1, record_byte: byte_s1, end_of_record: last_s1};

endmodule

// ===== hdl/avccr_parser.sv =====
module avccr_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  avccr_pkg::byte_item_t item_s1,
	output avccr_pkg::result_t    result
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_SKIP,
		PH_PPS_CNT,
		PH_DONE,
		PH_FAILED
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [7:0]  sets_left_q, sets_left_d;
	logic [1:0]  err_q, err_d;
	logic        in_pps_q, in_pps_d;
	logic [7:0]  profile_q, profile_d;
	logic [7:0]  compat_q, compat_d;
	logic [7:0]  level_q, level_d;
	logic [1:0]  lsm1_q, lsm1_d;
	logic [4:0]  sps_q, sps_d;
	logic [7:0]  pps_q, pps_d;
	logic [7:0]  b;
	logic [1:0]  err_out;

	assign b = item_s1.record_byte;

	always_comb begin
		phase_d     = phase_q;
		hdr_idx_d   = hdr_idx_q;
		skip_d      = skip_q;
		len_hi_d    = len_hi_q;
		sets_left_d = sets_left_q;
		err_d       = err_q;
		in_pps_d    = in_pps_q;
		profile_d   = profile_q;
		compat_d    = compat_q;
		level_d     = level_q;
		lsm1_d      = lsm1_q;
		sps_d       = sps_q;
		pps_d       = pps_q;

		if (hdr_idx_q != avccr_pkg::MIN_RECORD_BYTES) begin
			hdr_idx_d = hdr_idx_q + 3'd1;
		end

		case (phase_q)
			PH_HEADER: begin
				case (hdr_idx_q)
					3'd0: begin
						if (b != avccr_pkg::VERSION_ONE) begin
							err_d   = avccr_pkg::ERR_VERSION;
							phase_d = PH_FAILED;
						end
					end
					3'd1: profile_d = b;
					3'd2: compat_d  = b;
					3'd3: level_d   = b;
					3'd4: begin
						if (b[7:2] != avccr_pkg::RES6_ALL_ONES) begin
							err_d   = avccr_pkg::ERR_RESERVED;
							phase_d = PH_FAILED;
						end else begin
							lsm1_d = b[1:0];
						end
					end
					default: begin
						if (b[7:5] != avccr_pkg::RES3_ALL_ONES) begin
							err_d   = avccr_pkg::ERR_RESERVED;
							phase_d = PH_FAILED;
						end else begin
							sps_d       = b[4:0];
							sets_left_d = {3'd0, b[4:0]};
							in_pps_d    = 1'b0;
							phase_d     = (b[4:0] == 5'd0) ? PH_PPS_CNT : PH_LEN_HI;
						end
					end
				endcase
			end
			PH_LEN_HI: begin
				len_hi_d = b;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				skip_d = {len_hi_q, b};
				if ({len_hi_q, b} == 16'd0) begin
					// empty entry: close this set now
					sets_left_d = sets_left_q - 8'd1;
					if (sets_left_q == 8'd1) begin
						phase_d = in_pps_q ? PH_DONE : PH_PPS_CNT;
					end else begin
						phase_d = PH_LEN_HI;
					end
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 16'd1;
				if (skip_q == 16'd1) begin
					sets_left_d = sets_left_q - 8'd1;
					if (sets_left_q == 8'd1) begin
						phase_d = in_pps_q ? PH_DONE : PH_PPS_CNT;
					end else begin
						phase_d = PH_LEN_HI;
					end
				end
			end
			PH_PPS_CNT: begin
				pps_d       = b;
				sets_left_d = b;
				in_pps_d    = 1'b1;
				phase_d     = (b == 8'd0) ? PH_DONE : PH_LEN_HI;
			end
			default: ;
		endcase

		// short record outranks any header error
		if (hdr_idx_d < avccr_pkg::MIN_RECORD_BYTES) begin
			err_out = avccr_pkg::ERR_TRUNC;
		end else if (err_d != avccr_pkg::ERR_NONE) begin
			err_out = err_d;
		end else if (phase_d != PH_DONE) begin
			err_out = avccr_pkg::ERR_TRUNC;
		end else begin
			err_out = avccr_pkg::ERR_NONE;
		end
	end

	assign result = '{
		record_ok:             (err_out == avccr_pkg::ERR_NONE),
		error_code:            err_out,
		profile:               profile_d,
		compatibility:         compat_d,
		level:                 level_d,
		length_size_minus_one: lsm1_d,
		sps_count:             sps_d,
		pps_count:             pps_d
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_idx_q   <= 3'd0;
			skip_q      <= 16'd0;
			len_hi_q    <= 8'd0;
			sets_left_q <= 8'd0;
			err_q       <= avccr_pkg::ERR_NONE;
			in_pps_q    <= 1'b0;
			profile_q   <= 8'd0;
			compat_q    <= 8'd0;
			level_q     <= 8'd0;
			lsm1_q      <= 2'd0;
			sps_q       <= 5'd0;
			pps_q       <= 8'd0;
		end else if (take) begin
			if (item_s1.end_of_record) begin
				// record closed: return to the start of a new one
				phase_q     <= PH_HEADER;
				hdr_idx_q   <= 3'd0;
				skip_q      <= 16'd0;
				len_hi_q    <= 8'd0;
				sets_left_q <= 8'd0;
				err_q       <= avccr_pkg::ERR_NONE;
				in_pps_q    <= 1'b0;
				profile_q   <= 8'd0;
				compat_q    <= 8'd0;
				level_q     <= 8'd0;
				lsm1_q      <= 2'd0;
				sps_q       <= 5'd0;
				pps_q       <= 8'd0;
			end else begin
				phase_q     <= phase_d;
				hdr_idx_q   <= hdr_idx_d;
				skip_q      <= skip_d;
				len_hi_q    <= len_hi_d;
				sets_left_q <= sets_left_d;
				err_q       <= err_d;
				in_pps_q    <= in_pps_d;
				profile_q   <= profile_d;
				compat_q    <= compat_d;
				level_q     <= level_d;
				lsm1_q      <= lsm1_d;
				sps_q       <= sps_d;
				pps_q       <= pps_d;
			end
		end
	end

endmodule

// ===== hdl/avccr_out_stage.sv =====
module avccr_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  avccr_pkg::result_t result,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               out_ready,
	output avccr_pkg::result_t result_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign out_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// ===== hdl/avc_config_record_checker.sv =====
// A result is registered: the final record byte passes through the input
// register, then the result register, which it enters once that is free.
// Throughput: one byte per cycle while the input side does not stall.
// The input side stalls only while a finished result waits to be taken.
// Reset (arst_n low) returns the parser to the start of a record and
// empties both registers.
module avc_config_record_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] record_byte,
	input  logic       end_of_record,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       record_ok,
	output logic [1:0] error_code,
	output logic [7:0] profile,
	output logic [7:0] compatibility,
	output logic [7:0] level,
	output logic [1:0] length_size_minus_one,
	output logic [4:0] sps_count,
	output logic [7:0] pps_count
);

	avccr_pkg::byte_item_t item_s1;
	avccr_pkg::result_t    result;
	avccr_pkg::result_t    result_q;
	logic                  out_ready;
	logic                  advance;

	// hold a final byte until the result register is free
	assign advance = item_s1.valid && (!item_s1.end_of_record || out_ready);

	avccr_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.record_byte   (record_byte),
		.end_of_record (end_of_record),
		.advance       (advance),
		.item_s1       (item_s1)
	);

	avccr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	avccr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && item_s1.end_of_record),
		.result    (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign record_ok             = result_q.record_ok;
	assign error_code            = result_q.error_code;
	assign profile               = result_q.profile;
	assign compatibility         = result_q.compatibility;
	assign level                 = result_q.level;
	assign length_size_minus_one = result_q.length_size_minus_one;
	assign sps_count             = result_q.sps_count;
	assign pps_count             = result_q.pps_count;

endmodule

// ===== dv/tb_avc_config_record_checker.sv =====
module tb_avc_config_record_checker;

	localparam int unsigned RUN_LIMIT    = 200000;
	localparam int unsigned STREAM_ITEMS = 850;
	localparam int unsigned HOLD_START   = 1500;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_LEN_HI,
		PARSE_LEN_LO,
		PARSE_SKIP,
		PARSE_PPS_COUNT,
		PARSE_DONE,
		PARSE_FAILED
	} parse_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] record_byte = 8'd0;
	logic       end_of_record = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       record_ok;
	logic [1:0] error_code;
	logic [7:0] profile;
	logic [7:0] compatibility;
	logic [7:0] level;
	logic [1:0] length_size_minus_one;
	logic [4:0] sps_count;
	logic [7:0] pps_count;

	avc_config_record_checker dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.record_byte          (record_byte),
		.end_of_record        (end_of_record),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.record_ok            (record_ok),
		.error_code           (error_code),
		.profile              (profile),
		.compatibility        (compatibility),
		.level                (level),
		.length_size_minus_one(length_size_minus_one),
		.sps_count            (sps_count),
		.pps_count            (pps_count)
	);

	always #2 clk = ~clk;

	avccr_pkg::byte_item_t record_stream[$];
	avccr_pkg::result_t    expected_reports[$];
	logic [7:0]  rec_bytes[$];
	int unsigned mismatches = 0;
	int unsigned cycle = 0;
	int unsigned sent_count = 0;
	int          big_left = 2;
	logic        hold_off = 1'b0;
	int unsigned hold_left = 0;
	logic        calm;

	// stretch of items with no idling on either side
	assign calm = (sent_count >= 300) && (sent_count < 450);

	// parser state as the block should hold it
	parse_phase_t       m_phase;
	logic [2:0]         m_count;
	logic [15:0]        m_skip;
	logic [7:0]         m_len_hi;
	logic [7:0]         m_sets;
	logic [1:0]         m_err;
	logic               m_in_pps;
	avccr_pkg::result_t m_cap;

	task automatic restart_parser();
		m_phase  = PARSE_HEADER;
		m_count  = 3'd0;
		m_skip   = 16'd0;
		m_len_hi = 8'd0;
		m_sets   = 8'd0;
		m_err    = avccr_pkg::ERR_NONE;
		m_in_pps = 1'b0;
		m_cap    = '0;
	endtask

	task automatic after_sets();
		m_phase = m_in_pps ? PARSE_DONE : PARSE_PPS_COUNT;
	endtask

	task automatic close_set();
		m_sets = m_sets - 8'd1;
		if (m_sets == 8'd0) begin
			after_sets();
		end else begin
			m_phase = PARSE_LEN_HI;
		end
	endtask

	task automatic parse_record_byte(input logic [7:0] b, input logic last);
		logic [2:0]         pos;
		avccr_pkg::result_t rep;
		pos = m_count;
		if (m_count < avccr_pkg::MIN_RECORD_BYTES)
			m_count = m_count + 3'd1;
		case (m_phase)
			PARSE_HEADER: begin
				case (pos)
					3'd0: begin
						if (b != avccr_pkg::VERSION_ONE) begin
							m_err   = avccr_pkg::ERR_VERSION;
							m_phase = PARSE_FAILED;
						end
					end
					3'd1: m_cap.profile = b;
					3'd2: m_cap.compatibility = b;
					3'd3: m_cap.level = b;
					3'd4: begin
						if (b[7:2] != avccr_pkg::RES6_ALL_ONES) begin
							m_err   = avccr_pkg::ERR_RESERVED;
							m_phase = PARSE_FAILED;
						end else begin
							m_cap.length_size_minus_one = b[1:0];
						end
					end
					default: begin
						if (b[7:5] != avccr_pkg::RES3_ALL_ONES) begin
							m_err   = avccr_pkg::ERR_RESERVED;
							m_phase = PARSE_FAILED;
						end else begin
							m_cap.sps_count = b[4:0];
							m_sets   = {3'd0, b[4:0]};
							m_in_pps = 1'b0;
							if (m_sets == 8'd0)
								after_sets();
							else
								m_phase = PARSE_LEN_HI;
						end
					end
				endcase
			end
			PARSE_LEN_HI: begin
				m_len_hi = b;
				m_phase  = PARSE_LEN_LO;
			end
			PARSE_LEN_LO: begin
				m_skip = {m_len_hi, b};
				if (m_skip == 16'd0)
					close_set();
				else
					m_phase = PARSE_SKIP;
			end
			PARSE_SKIP: begin
				m_skip = m_skip - 16'd1;
				if (m_skip == 16'd0)
					close_set();
			end
			PARSE_PPS_COUNT: begin
				m_cap.pps_count = b;
				m_sets   = b;
				m_in_pps = 1'b1;
				m_phase  = (b == 8'd0) ? PARSE_DONE : PARSE_LEN_HI;
			end
			default: ;
		endcase
		if (last) begin
			rep = m_cap;
			if (m_count < avccr_pkg::MIN_RECORD_BYTES)
				rep.error_code = avccr_pkg::ERR_TRUNC;
			else if (m_err != avccr_pkg::ERR_NONE)
				rep.error_code = m_err;
			else if (m_phase != PARSE_DONE)
				rep.error_code = avccr_pkg::ERR_TRUNC;
			else
				rep.error_code = avccr_pkg::ERR_NONE;
			rep.record_ok = (rep.error_code == avccr_pkg::ERR_NONE);
			expected_reports.push_back(rep);
			restart_parser();
		end
	endtask

	// ---- stimulus construction ----

	task automatic put_byte(input logic [7:0] b);
		rec_bytes.push_back(b);
	endtask

	task automatic put_random(input int n);
		for (int i = 0; i < n; i++)
			put_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_record();
		avccr_pkg::byte_item_t item;
		for (int i = 0; i < rec_bytes.size(); i++) begin
			item.valid         = 1'b1;
			item.record_byte   = rec_bytes[i];
			item.end_of_record = (i == rec_bytes.size() - 1);
			record_stream.push_back(item);
		end
		rec_bytes.delete();
	endtask

	function automatic int pick_length();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 40)
			return int'($urandom_range(0, 2));
		if (r < 98 || big_left == 0)
			return int'($urandom_range(3, 8));
		big_left--;
		return 256 + int'($urandom_range(0, 12));
	endfunction

	task automatic add_sets(input int n, input bit tiny);
		int          len;
		logic [15:0] len16;
		for (int i = 0; i < n; i++) begin
			len   = tiny ? int'($urandom_range(0, 2)) : pick_length();
			len16 = 16'(len);
			put_byte(len16[15:8]);
			put_byte(len16[7:0]);
			put_random(len);
		end
	endtask

	task automatic build_good(input bit trailing, input bit wide_pps);
		int sps;
		int pps;
		sps = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 31))
		                                  : int'($urandom_range(0, 3));
		if (wide_pps)
			pps = int'($urandom_range(0, 255));
		else if ($urandom_range(0, 9) == 0)
			pps = int'($urandom_range(0, 15));
		else
			pps = int'($urandom_range(0, 3));
		put_byte(avccr_pkg::VERSION_ONE);
		put_random(3);
		put_byte(8'hFC | 8'($urandom_range(0, 3)));
		put_byte(8'hE0 | 8'(sps));
		add_sets(sps, sps > 4);
		put_byte(8'(pps));
		add_sets(pps, pps > 4);
		if (trailing)
			put_random(int'($urandom_range(0, 3)));
	endtask

	task automatic corrupt_header(input int which);
		int v;
		case (which)
			0: begin
				v = int'($urandom_range(0, 254));
				if (v >= 1)
					v++;
				rec_bytes[0] = 8'(v);
			end
			1: rec_bytes[4] = {6'($urandom_range(0, 62)), 2'($urandom_range(0, 3))};
			default: rec_bytes[5] = {3'($urandom_range(0, 6)), 5'($urandom_range(0, 31))};
		endcase
	endtask

	task automatic build_random_record();
		int r;
		int cut;
		int which;
		r = int'($urandom_range(0, 99));
		if (r < 60) begin
			build_good(1'b1, 1'b0);
		end else if (r < 75) begin
			// cut a well-formed record short
			build_good(1'b0, $urandom_range(0, 1) == 1);
			cut = int'($urandom_range(1, (rec_bytes.size() - 1 < 24) ?
			                             rec_bytes.size() - 1 : 24));
			while (rec_bytes.size() > cut)
				void'(rec_bytes.pop_back());
		end else if (r < 90) begin
			build_good(1'b1, 1'b0);
			which = int'($urandom_range(0, 2));
			corrupt_header(which);
			// sometimes a second, later header error that must not win
			if (which < 2 && $urandom_range(0, 3) == 0)
				corrupt_header(2);
			put_random(int'($urandom_range(0, 3)));
		end else begin
			put_random(int'($urandom_range(1, 12)));
		end
		send_record();
	endtask

	task automatic put_list(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
	                        input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
	                        input logic [7:0] b6);
		put_byte(b0); put_byte(b1); put_byte(b2); put_byte(b3);
		put_byte(b4); put_byte(b5); put_byte(b6);
		send_record();
	endtask

	// ---- driver ----

	int tx_gap = 0;

	always @(posedge clk) begin
		avccr_pkg::byte_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				parse_record_byte(record_byte, end_of_record);
				sent_count <= sent_count + 1;
				tx_gap = calm ? 0 : int'($urandom_range(0, 9));
			end
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (record_stream.size() > 0) begin
				item = record_stream.pop_front();
				in_valid      <= 1'b1;
				record_byte   <= item.record_byte;
				end_of_record <= item.end_of_record;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---- receiver hold-off: long stall while the sender keeps offering ----

	always @(posedge clk) begin
		if (!arst_n) begin
			hold_off  <= 1'b0;
			hold_left <= 0;
		end else if (cycle == HOLD_START) begin
			hold_off  <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				hold_off <= 1'b0;
		end
	end

	// ---- monitor ----

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	int rx_wait = 0;

	always @(posedge clk) begin
		avccr_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with no record pending");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("record_ok", 8'(want.record_ok), 8'(record_ok));
					check_field("error_code", 8'(want.error_code), 8'(error_code));
					check_field("profile", want.profile, profile);
					check_field("compatibility", want.compatibility, compatibility);
					check_field("level", want.level, level);
					check_field("length_size_minus_one", 8'(want.length_size_minus_one),
					            8'(length_size_minus_one));
					check_field("sps_count", 8'(want.sps_count), 8'(sps_count));
					check_field("pps_count", want.pps_count, pps_count);
				end
				rx_wait = calm ? 0 : int'($urandom_range(0, 9));
			end else if (out_valid && rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= hold_off || (rx_wait > 0);
		end
	end

	// ---- watchdog ----

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == RUN_LIMIT) begin
			$display("avc_config_record_checker: mismatch");
			$finish;
		end
	end

	initial begin
		restart_parser();

		// minimal passing record, all fields zero
		put_list(8'h01, 8'h00, 8'h00, 8'h00, 8'hFC, 8'hE0, 8'h00);
		// single-byte record: truncated even though the version is wrong
		put_byte(8'hFF);
		send_record();
		// bad version: nothing captured afterwards
		put_list(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// bad 3-bit reserved field: length size kept, SPS count dropped
		put_list(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'h00);
		// body ends inside the first SPS length
		put_list(8'h01, 8'h64, 8'h00, 8'h28, 8'hFF, 8'hE1, 8'h00);

		while (record_stream.size() < STREAM_ITEMS)
			build_random_record();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (record_stream.size() > 0 || in_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("avc_config_record_checker: match");
		end else begin
			$display("avc_config_record_checker: mismatch");
		end
		$finish;
	end

endmodule
